// ===== src/jesc_pkg.sv =====
// shared types, constants and helpers for the json string escaper
// used by every module of the block; depends on nothing

package jesc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CAP_W       = 16;
   localparam int CMP_W       = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;
   localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_U = 8'h75;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [7:0] MASK_CONT = 8'hC0;
   localparam logic [7:0] CODE_CONT = 8'h80;
   localparam logic [7:0] MASK_LEAD2 = 8'hE0;
   localparam logic [7:0] CODE_LEAD2 = 8'hC0;
   localparam logic [7:0] MASK_LEAD3 = 8'hF0;
   localparam logic [7:0] CODE_LEAD3 = 8'hE0;
   localparam logic [7:0] MASK_LEAD4 = 8'hF8;
   localparam logic [7:0] CODE_LEAD4 = 8'hF0;

   typedef enum logic [2:0] {
      MAIN_NONE,
      MAIN_BYTE,
      MAIN_ESC,
      MAIN_UNI,
      MAIN_ZERO
   } main_kind_type;

   typedef struct packed {
      logic [2:0][7:0] rel_bytes;
      logic [1:0]      rel_cnt;
      main_kind_type   kind;
      logic [7:0]      main_byte;
      logic [3:0]      total;
      logic            trunc;
   } job_type;

   function automatic logic [3:0] kind_len(input main_kind_type kind);
      logic [3:0] len;
      case (kind)
         MAIN_BYTE: len = 4'd1;
         MAIN_ESC:  len = 4'd2;
         MAIN_UNI:  len = 4'd6;
         MAIN_ZERO: len = 4'd1;
         default:   len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      if (v < 4'd10) begin
         d = CHAR_ZERO + {4'd0, v};
      end else begin
         d = CHAR_LOWER_A + {4'd0, v - 4'd10};
      end
      return d;
   endfunction

endpackage

// ===== src/jesc_front.sv =====
// front end: takes input beats, applies the capacity rule and utf-8 hold,
// and turns each beat with output into a job descriptor; depends on jesc_pkg

module jesc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       byte_in,
   input  logic             end_of_string,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data,
   output logic             push,
   output jesc_pkg::job_type job
);

   localparam int CW = jesc_pkg::COUNT_WIDTH;
   localparam int MW = jesc_pkg::CMP_W;

   logic [jesc_pkg::CAP_W-1:0] capacity_ff;
   logic [CW-1:0]              bw_ff, bw_in;
   logic                       trunc_ff, trunc_in;
   logic [2:0][7:0]            held_ff, held_in;
   logic [1:0]                 hc_ff, hc_in;
   logic [1:0]                 cn_ff, cn_in;

   logic [MW-1:0] cap_lim, cap_raw, cap_eff, fill;
   logic [2:0]    need;
   logic          fits, fits_one, is_cont, term_trunc;
   logic [1:0]    lead_need;
   logic [7:0]    esc_char;

   always_comb begin
      cap_lim  = MW'(1) << CW;
      cap_raw  = (capacity_ff == '0) ? MW'(1) : MW'(capacity_ff);
      cap_eff  = (cap_raw > cap_lim) ? cap_lim : cap_raw;
      fill     = MW'(bw_ff) + MW'(hc_ff);
      if (byte_in inside {jesc_pkg::CHAR_QUOTE, jesc_pkg::CHAR_BSLASH, jesc_pkg::CHAR_LF,
                          jesc_pkg::CHAR_CR, jesc_pkg::CHAR_TAB}) begin
         need = 3'd2;
      end else if (byte_in < jesc_pkg::CTRL_LIMIT) begin
         need = 3'd6;
      end else begin
         need = 3'd1;
      end
      fits       = (fill + MW'(need)) < cap_eff;
      fits_one   = (fill + MW'(1)) < cap_eff;
      is_cont    = (hc_ff != 2'd0) && ((byte_in & jesc_pkg::MASK_CONT) == jesc_pkg::CODE_CONT);
      term_trunc = trunc_ff || ((hc_ff != 2'd0) && !fits_one);
      if ((byte_in & jesc_pkg::MASK_LEAD2) == jesc_pkg::CODE_LEAD2) begin
         lead_need = 2'd1;
      end else if ((byte_in & jesc_pkg::MASK_LEAD3) == jesc_pkg::CODE_LEAD3) begin
         lead_need = 2'd2;
      end else if ((byte_in & jesc_pkg::MASK_LEAD4) == jesc_pkg::CODE_LEAD4) begin
         lead_need = 2'd3;
      end else begin
         lead_need = 2'd0;
      end
      case (byte_in)
         jesc_pkg::CHAR_LF:  esc_char = jesc_pkg::CHAR_N;
         jesc_pkg::CHAR_CR:  esc_char = jesc_pkg::CHAR_R;
         jesc_pkg::CHAR_TAB: esc_char = jesc_pkg::CHAR_T;
         default:            esc_char = byte_in;
      endcase
   end

   always_comb begin
      bw_in          = bw_ff;
      trunc_in       = trunc_ff;
      held_in        = held_ff;
      hc_in          = hc_ff;
      cn_in          = cn_ff;
      job            = '0;
      job.rel_bytes  = held_ff;
      job.kind       = jesc_pkg::MAIN_NONE;
      if (accept) begin
         if (end_of_string) begin
            if ((hc_ff != 2'd0) && !term_trunc) begin
               job.rel_cnt = hc_ff;
            end
            job.kind  = jesc_pkg::MAIN_ZERO;
            job.trunc = term_trunc;
            trunc_in  = 1'b0;
            hc_in     = 2'd0;
            cn_in     = 2'd0;
         end else if (!trunc_ff) begin
            if (!fits) begin
               trunc_in = 1'b1;
               hc_in    = 2'd0;
               cn_in    = 2'd0;
            end else if (is_cont) begin
               if (cn_ff <= 2'd1) begin
                  job.rel_cnt   = hc_ff;
                  job.kind      = jesc_pkg::MAIN_BYTE;
                  job.main_byte = byte_in;
                  hc_in         = 2'd0;
                  cn_in         = 2'd0;
               end else begin
                  held_in[hc_ff] = byte_in;
                  hc_in          = hc_ff + 2'd1;
                  cn_in          = cn_ff - 2'd1;
               end
            end else begin
               job.rel_cnt = hc_ff;
               hc_in       = 2'd0;
               cn_in       = 2'd0;
               if (need == 3'd2) begin
                  job.kind      = jesc_pkg::MAIN_ESC;
                  job.main_byte = esc_char;
               end else if (need == 3'd6) begin
                  job.kind      = jesc_pkg::MAIN_UNI;
                  job.main_byte = byte_in;
               end else if (lead_need != 2'd0) begin
                  held_in[0] = byte_in;
                  hc_in      = 2'd1;
                  cn_in      = lead_need;
               end else begin
                  job.kind      = jesc_pkg::MAIN_BYTE;
                  job.main_byte = byte_in;
               end
            end
         end
      end
      job.total = {2'd0, job.rel_cnt} + jesc_pkg::kind_len(job.kind);
      push      = accept && (job.total != 4'd0);
      if (accept) begin
         bw_in = end_of_string ? '0 : bw_ff + CW'(job.total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= jesc_pkg::CAP_RESET;
         bw_ff       <= '0;
         trunc_ff    <= 1'b0;
         hc_ff       <= 2'd0;
         cn_ff       <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         bw_ff    <= bw_in;
         trunc_ff <= trunc_in;
         hc_ff    <= hc_in;
         cn_ff    <= cn_in;
      end
      held_ff <= held_in;
   end

   a_trunc_no_hold: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> (hc_ff == 2'd0) && (cn_ff == 2'd0))
      else $error("hold not cleared while truncated");

   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      (hc_ff == 2'd0) |-> (cn_ff == 2'd0))
      else $error("continuations pending with nothing held");

   a_seq_len: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, hc_ff} + {1'b0, cn_ff}) <= 3'd4)
      else $error("utf-8 hold longer than four bytes");

endmodule

// ===== src/jesc_queue.sv =====
// small job queue between front and back ends
// depends on jesc_pkg for the job type and depth

module jesc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jesc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output jesc_pkg::job_type head
);

   localparam int PW = jesc_pkg::QPTR_W;

   jesc_pkg::job_type      q_ff [jesc_pkg::QUEUE_DEPTH];
   logic [PW-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]            cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   always_comb begin
      full    = cnt_ff == (PW+1)'(jesc_pkg::QUEUE_DEPTH);
      empty   = cnt_ff == '0;
      head    = q_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in   = do_pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in  = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== src/jesc_back.sv =====
// back end: walks the head job, one output byte per cycle unless
// rsp_tready stalls, into the output register; depends on jesc_pkg

module jesc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  jesc_pkg::job_type head,
   output logic             pop,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [7:0]       out_byte,
   output logic             run_last,
   output logic             is_terminator,
   output logic             was_truncated
);

   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       term_ff, term_in;
   logic       trunc_ff, trunc_in;
   logic       load;
   logic [3:0] j;

   always_comb begin
      j = step_ff - {2'd0, head.rel_cnt};
      if (step_ff < {2'd0, head.rel_cnt}) begin
         byte_in = head.rel_bytes[step_ff[1:0]];
      end else begin
         case (head.kind)
            jesc_pkg::MAIN_ESC: begin
               byte_in = (j == 4'd0) ? jesc_pkg::CHAR_BSLASH : head.main_byte;
            end
            jesc_pkg::MAIN_UNI: begin
               case (j)
                  4'd0:    byte_in = jesc_pkg::CHAR_BSLASH;
                  4'd1:    byte_in = jesc_pkg::CHAR_U;
                  4'd4:    byte_in = jesc_pkg::hex_digit(head.main_byte[7:4]);
                  4'd5:    byte_in = jesc_pkg::hex_digit(head.main_byte[3:0]);
                  default: byte_in = jesc_pkg::CHAR_ZERO;
               endcase
            end
            jesc_pkg::MAIN_BYTE: byte_in = head.main_byte;
            default:             byte_in = 8'd0;
         endcase
      end
      last_in  = step_ff == (head.total - 4'd1);
      term_in  = last_in && (head.kind == jesc_pkg::MAIN_ZERO);
      trunc_in = term_in && head.trunc;
      load     = !empty && (!valid_ff || rsp_tready);
      pop      = load && last_in;
      if (load) begin
         step_in  = last_in ? 4'd0 : step_ff + 4'd1;
         valid_in = 1'b1;
      end else begin
         step_in  = step_ff;
         valid_in = valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         byte_ff  <= byte_in;
         last_ff  <= last_in;
         term_ff  <= term_in;
         trunc_ff <= trunc_in;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign out_byte      = byte_ff;
   assign run_last      = last_ff;
   assign is_terminator = term_ff;
   assign was_truncated = trunc_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> step_ff < head.total)
      else $error("step beyond job length");

   a_no_empty_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> head.total != 4'd0)
      else $error("queued job with no output");

   a_trunc_on_term: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && trunc_ff) |-> (term_ff && last_ff))
      else $error("truncation flag off the terminator");

endmodule

// ===== src/json_escape_utf8_safe_truncate.sv =====
// Streaming JSON string escaper with a capacity bound and a UTF-8-safe cut.
// One input beat is taken per cycle while the four-entry job queue has room;
// the back end emits one output byte per cycle unless rsp_tready stalls it,
// and each item produces 0 to 9 bytes (one for most bytes, two for short
// escapes, six for \u00xx, plus any released UTF-8 bytes).
// The first result of an item passes the job queue, then the output register.
// Depends on jesc_pkg, jesc_front, jesc_queue and jesc_back.

module json_escape_utf8_safe_truncate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_in
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser,   // was_truncated, is_terminator
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // capacity
);

   logic              accept, push, pop, full, empty;
   logic              is_term, was_trunc;
   jesc_pkg::job_type job, head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   jesc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_in       (req_tdata),
      .end_of_string (req_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .push          (push),
      .job           (job)
   );

   jesc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   jesc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .head          (head),
      .pop           (pop),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .out_byte      (rsp_tdata),
      .run_last      (rsp_tlast),
      .is_terminator (is_term),
      .was_truncated (was_trunc)
   );

   assign rsp_tuser = {was_trunc, is_term};

endmodule

// ===== tb/json_escape_utf8_safe_truncate_tb.sv =====
// self-checking testbench for the streaming json string escaper with capacity cut
// predicts every escaped byte per accepted beat and checks the result stream in order
// depends on jesc_pkg and json_escape_utf8_safe_truncate

module json_escape_utf8_safe_truncate_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 480;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_PRINTED    = 40;
   localparam logic [7:0] ESC_SET [5] = '{jesc_pkg::CHAR_QUOTE, jesc_pkg::CHAR_BSLASH,
                                          jesc_pkg::CHAR_LF, jesc_pkg::CHAR_CR,
                                          jesc_pkg::CHAR_TAB};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } src_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       term;
      logic       cut;
   } esc_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = jesc_pkg::CAP_RESET;

   json_escape_utf8_safe_truncate dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   src_beat_type src_pending [$];
   esc_beat_type esc_expect [$];
   logic [1:0]  idle_mode = 2'b00;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          quiet_cycles = 0;
   int          error_count = 0;
   int          items_queued = 0;
   int          in_beats = 0;
   int          out_beats = 0;
   int          strings_seen = 0;
   int          cut_strings = 0;
   int          cfg_writes = 0;

   // escaper state as the block should hold it
   logic [15:0] capacity_model = jesc_pkg::CAP_RESET;
   logic [15:0] bytes_out = 16'd0;
   logic        cut_flag = 1'b0;
   logic [7:0]  hold_buf [0:2];
   logic [1:0]  hold_cnt = 2'd0;
   logic [1:0]  conts_left = 2'd0;
   logic [7:0]  obuf [0:9];
   int          ocnt = 0;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h57 + 8'(nib));
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      obuf[ocnt] = b;
      ocnt++;
      bytes_out++;
   endfunction

   function automatic void release_held();
      for (int i = 0; i < int'(hold_cnt); i++) put_byte(hold_buf[i]);
      hold_cnt = 2'd0;
      conts_left = 2'd0;
   endfunction

   function automatic void drop_held();
      hold_cnt = 2'd0;
      conts_left = 2'd0;
   endfunction

   function automatic void escape_predict(input logic [7:0] c, input logic eos);
      int cap_eff;
      int fill;
      int need;
      logic cut_now;
      logic is_cont;
      esc_beat_type b;
      ocnt = 0;
      cut_now = 1'b0;
      cap_eff = (capacity_model == 16'd0) ? 1 : int'(capacity_model);
      fill = int'(bytes_out) + int'(hold_cnt);
      if (eos) begin
         if (hold_cnt != 2'd0) begin
            if (cut_flag || fill + 1 >= cap_eff) begin
               cut_flag = 1'b1;
               drop_held();
            end else begin
               release_held();
            end
         end
         put_byte(8'h00);
         cut_now = cut_flag;
         bytes_out = 16'd0;
         cut_flag = 1'b0;
         drop_held();
         strings_seen++;
      end else if (!cut_flag) begin
         is_cont = (hold_cnt != 2'd0) &&
                   ((c & jesc_pkg::MASK_CONT) == jesc_pkg::CODE_CONT);
         if (c == jesc_pkg::CHAR_QUOTE || c == jesc_pkg::CHAR_BSLASH ||
             c == jesc_pkg::CHAR_LF || c == jesc_pkg::CHAR_CR ||
             c == jesc_pkg::CHAR_TAB) begin
            need = 2;
         end else if (c < jesc_pkg::CTRL_LIMIT) begin
            need = 6;
         end else begin
            need = 1;
         end
         if (fill + need >= cap_eff) begin
            cut_flag = 1'b1;
            drop_held();
         end else if (is_cont && conts_left > 2'd1) begin
            hold_buf[hold_cnt] = c;
            hold_cnt++;
            conts_left--;
         end else if (is_cont) begin
            release_held();
            put_byte(c);
         end else begin
            release_held();
            if (need == 2) begin
               put_byte(jesc_pkg::CHAR_BSLASH);
               put_byte((c == jesc_pkg::CHAR_LF) ? jesc_pkg::CHAR_N :
                        (c == jesc_pkg::CHAR_CR) ? jesc_pkg::CHAR_R :
                        (c == jesc_pkg::CHAR_TAB) ? jesc_pkg::CHAR_T : c);
            end else if (need == 6) begin
               put_byte(jesc_pkg::CHAR_BSLASH);
               put_byte(jesc_pkg::CHAR_U);
               put_byte(jesc_pkg::CHAR_ZERO);
               put_byte(jesc_pkg::CHAR_ZERO);
               put_byte(hex_char(c[7:4]));
               put_byte(hex_char(c[3:0]));
            end else begin
               if ((c & jesc_pkg::MASK_LEAD2) == jesc_pkg::CODE_LEAD2) conts_left = 2'd1;
               else if ((c & jesc_pkg::MASK_LEAD3) == jesc_pkg::CODE_LEAD3) conts_left = 2'd2;
               else if ((c & jesc_pkg::MASK_LEAD4) == jesc_pkg::CODE_LEAD4) conts_left = 2'd3;
               if (conts_left != 2'd0) begin
                  hold_buf[0] = c;
                  hold_cnt = 2'd1;
               end else begin
                  put_byte(c);
               end
            end
         end
      end
      for (int i = 0; i < ocnt; i++) begin
         b.data = obuf[i];
         b.last = (i == ocnt - 1);
         b.term = eos && (i == ocnt - 1);
         b.cut  = eos && (i == ocnt - 1) && cut_now;
         esc_expect.push_back(b);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("mismatch at output beat %0d: %s", out_beats, msg);
      error_count++;
   endtask

   // input driver
   always @(posedge clock) begin : req_driver
      logic nv;
      src_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         nv = req_tvalid;
         if (req_tvalid && req_tready) begin
            escape_predict(req_tdata, req_tlast);
            in_beats++;
            nv = 1'b0;
         end
         if (!nv) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
            end else if (src_pending.size() != 0) begin
               nxt = src_pending.pop_front();
               req_tdata <= nxt.data;
               req_tlast <= nxt.last;
               nv = 1'b1;
               req_gap <= idle_mode[0] ? $urandom_range(0, 3) : 0;
            end
         end
         req_tvalid <= nv;
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      int g;
      esc_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (esc_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected beat data %h last %b user %b",
                                         rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               want = esc_expect.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("out_byte %h, expected %h", rsp_tdata, want.data));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("run_last %b, expected %b", rsp_tlast, want.last));
               if (rsp_tuser[0] !== want.term)
                  report_mismatch($sformatf("is_terminator %b, expected %b",
                                            rsp_tuser[0], want.term));
               if (rsp_tuser[1] !== want.cut)
                  report_mismatch($sformatf("was_truncated %b, expected %b",
                                            rsp_tuser[1], want.cut));
            end
            if (rsp_tuser[0] && rsp_tuser[1]) cut_strings++;
            out_beats++;
            g = idle_mode[1] ? $urandom_range(0, 3) : 0;
         end else begin
            g = (rsp_gap != 0) ? rsp_gap - 1 : 0;
         end
         rsp_gap <= g;
         rsp_tready <= (g == 0);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stream stalled: %0d items pending, %0d results still expected",
                  src_pending.size(), esc_expect.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      src_pending.push_back('{b, 1'b0});
      items_queued++;
   endtask

   task automatic queue_end();
      src_pending.push_back('{8'($urandom), 1'b1});
      items_queued++;
   endtask

   function automatic logic [7:0] lead_byte(input int n);
      case (n)
         1:       return jesc_pkg::CODE_LEAD2 | 8'($urandom_range(0, 31));
         2:       return jesc_pkg::CODE_LEAD3 | 8'($urandom_range(0, 15));
         default: return jesc_pkg::CODE_LEAD4 | 8'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return jesc_pkg::CODE_CONT | 8'($urandom_range(0, 63));
   endfunction

   task automatic queue_string(input int max_len);
      int len;
      int k;
      int n;
      int m;
      len = $urandom_range(0, max_len);
      k = 0;
      while (k < len) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3: queue_byte(8'($urandom_range(32, 126)));
            4: queue_byte(ESC_SET[$urandom_range(0, 4)]);
            5: queue_byte(8'($urandom_range(0, 31)));
            6, 7, 8: begin
               n = $urandom_range(1, 3);
               queue_byte(lead_byte(n));
               repeat (n) queue_byte(cont_byte());
               k += n;
            end
            9: begin
               // sequence cut off early
               n = $urandom_range(1, 3);
               m = $urandom_range(0, n - 1);
               queue_byte(lead_byte(n));
               repeat (m) queue_byte(cont_byte());
               k += m;
            end
            10: queue_byte($urandom_range(0, 1) ? cont_byte() : 8'($urandom_range(248, 255)));
            default: queue_byte(8'($urandom));
         endcase
         k++;
      end
      queue_end();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (src_pending.size() != 0 || req_tvalid || esc_expect.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      capacity_model = v;
      cfg_writes++;
   endtask

   initial begin : sequencer
      logic [7:0] dir_a [0:18];
      logic [15:0] cap;
      int phase;
      int base;
      dir_a = '{8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h00, 8'h1F, 8'h20, 8'h80, 8'hC3,
                8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hC3, 8'h41, 8'hF8, 8'hFF, 8'h7F};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: every escape class, utf-8 hold and release, cut with discard
      write_capacity(jesc_pkg::CAP_RESET);
      idle_mode = 2'b11;
      foreach (dir_a[i]) queue_byte(dir_a[i]);
      queue_end();
      wait_idle();
      write_capacity(16'd4);
      queue_byte(8'h61);
      queue_byte(8'h62);
      queue_byte(8'hC3);
      queue_byte(8'hA9);
      queue_end();
      queue_byte(8'hE2);
      queue_end();
      wait_idle();
      write_capacity(16'd3);
      queue_byte(8'h61);
      queue_byte(8'hC3);
      queue_end();

      base = items_queued;
      phase = 0;
      while (items_queued - base < RANDOM_ITEMS) begin
         case (phase % 7)
            0:       cap = 16'd1;
            1:       cap = 16'($urandom_range(2, 10));
            2:       cap = 16'hFFFF;
            3:       cap = 16'd0;
            4:       cap = 16'($urandom_range(11, 48));
            5:       cap = jesc_pkg::CAP_RESET;
            default: cap = 16'($urandom_range(2, 24));
         endcase
         wait_idle();
         write_capacity(cap);
         idle_mode = 2'($urandom_range(0, 3));
         phase++;
         while (items_queued - base < phase * 48)
            queue_string(($urandom_range(0, 7) == 0) ? 40 : 10);
      end
      wait_idle();

      $display("escaped %0d strings from %0d input beats into %0d output beats",
               strings_seen, in_beats, out_beats);
      $display("%0d strings cut short across %0d capacity writes", cut_strings, cfg_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
